// File: hw/rtl/hsv_to_rgb_converter_macros.svh
// Assertion helpers shared by the converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HSV_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSV_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned InW    = 9;
  localparam int unsigned ProdW  = 17;  // s*v and v*(256-s), at most 65536
  localparam int unsigned FixW   = 22;  // units of 1/(65536*60), at most 3932160

  localparam logic [InW-1:0] HueMax  = 9'd360;
  localparam logic [InW-1:0] UnitOne = 9'd256;
  localparam logic [5:0]     SectorDeg = 6'd60;
  localparam logic [4:0]     ScaleMul  = 5'd17;  // 255/60 = 17/4
  localparam int unsigned    ScaleShift = 18;    // 65536*4

  typedef enum logic [2:0] {
    SecRedYel,
    SecYelGrn,
    SecGrnCyn,
    SecCynBlu,
    SecBluMag,
    SecMagRed
  } sector_e;

  typedef struct packed {
    logic [InW-1:0] hue;
    logic [InW-1:0] saturation;
    logic [InW-1:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic             valid_res;
  } rgb_t;

endpackage

// File: hw/rtl/hsv_to_rgb_converter.sv
// Channel  Direction  Handshake            Payload
// in       request in in_valid_i/in_stall_o  hsv_t: hue, saturation, brightness
// out      result out out_valid_o/out_stall_i rgb_t: red, green, blue, valid_res
//
// Takes one request per cycle while in_stall_o is low; each result is offered
// from the last of four register stages (range check and two 9x9 products, scaling
// by 60 and hue weight, channel sums, final x17>>18 scale). Reset empties all four stages.
// A stalled output holds its result; bubbles close up, so the input stalls only
// when every stage is full and the output is stalled.
`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  hsv2rgb_pkg::hsv_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output hsv2rgb_pkg::rgb_t out_data_o
);

  localparam int unsigned ProdW = hsv2rgb_pkg::ProdW;
  localparam int unsigned FixW  = hsv2rgb_pkg::FixW;
  localparam int unsigned InW   = hsv2rgb_pkg::InW;
  localparam int unsigned ChanW = hsv2rgb_pkg::ChanW;
  localparam int unsigned MulW  = FixW + 5;

  function automatic logic [ChanW-1:0] scale_chan(input logic [FixW-1:0] n);
    logic [MulW-1:0] t;
    t = MulW'(n) * MulW'(hsv2rgb_pkg::ScaleMul);
    if (t[MulW-1:hsv2rgb_pkg::ScaleShift] > (MulW - hsv2rgb_pkg::ScaleShift)'(8'd255)) begin
      return 8'd255;
    end
    return t[hsv2rgb_pkg::ScaleShift +: ChanW];
  endfunction

  // Stage valid and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4 = !v4_q || !out_stall_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_stall_o = !rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: range check, sector, hue weight, products
  logic                 ok1_d, ok1_q;
  hsv2rgb_pkg::sector_e sec1_d, sec1_q;
  logic [InW-1:0]       hm, hdist, wt;
  logic [5:0]           f1_d, f1_q;
  logic [ProdW-1:0]     p1_d, p1_q, q1_d, q1_q;
  logic [InW-1:0]       h, s, v, sinv;

  always_comb begin
    h = in_data_i.hue;
    s = in_data_i.saturation;
    v = in_data_i.brightness;
    ok1_d = (h <= hsv2rgb_pkg::HueMax) && (s <= hsv2rgb_pkg::UnitOne) &&
            (v <= hsv2rgb_pkg::UnitOne);
    if      (h < 9'd60)  sec1_d = hsv2rgb_pkg::SecRedYel;
    else if (h < 9'd120) sec1_d = hsv2rgb_pkg::SecYelGrn;
    else if (h < 9'd180) sec1_d = hsv2rgb_pkg::SecGrnCyn;
    else if (h < 9'd240) sec1_d = hsv2rgb_pkg::SecCynBlu;
    else if (h < 9'd300) sec1_d = hsv2rgb_pkg::SecBluMag;
    else                 sec1_d = hsv2rgb_pkg::SecMagRed;
    // hue 360 lands on hm = 120, which gives weight 0 just as hm = 0 does
    if      (h >= 9'd240) hm = h - 9'd240;
    else if (h >= 9'd120) hm = h - 9'd120;
    else                  hm = h;
    hdist = (hm >= 9'd60) ? hm - 9'd60 : 9'd60 - hm;
    wt    = 9'd60 - hdist;
    f1_d  = wt[5:0];
    sinv  = hsv2rgb_pkg::UnitOne - s;
    p1_d  = ProdW'(s) * ProdW'(v);
    q1_d  = ProdW'(v) * ProdW'(sinv);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      ok1_q  <= ok1_d;
      sec1_q <= sec1_d;
      f1_q   <= f1_d;
      p1_q   <= p1_d;
      q1_q   <= q1_d;
    end
  end

  // Stage 2: C, X and m in fixed units
  logic                 ok2_q;
  hsv2rgb_pkg::sector_e sec2_q;
  logic [FixW-1:0]      c2_q, x2_q, m2_q;

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      ok2_q  <= ok1_q;
      sec2_q <= sec1_q;
      c2_q   <= FixW'(p1_q) * FixW'(hsv2rgb_pkg::SectorDeg);
      x2_q   <= FixW'(p1_q) * FixW'(f1_q);
      m2_q   <= FixW'(q1_q) * FixW'(hsv2rgb_pkg::SectorDeg);
    end
  end

  // Stage 3: place C and X by sector and add m
  logic            ok3_q;
  logic [FixW-1:0] cm, xm;
  logic [FixW-1:0] r3_d, g3_d, b3_d, r3_q, g3_q, b3_q;

  always_comb begin
    cm = c2_q + m2_q;
    xm = x2_q + m2_q;
    r3_d = m2_q;
    g3_d = m2_q;
    b3_d = m2_q;
    unique case (sec2_q)
      hsv2rgb_pkg::SecRedYel: begin r3_d = cm; g3_d = xm; end
      hsv2rgb_pkg::SecYelGrn: begin r3_d = xm; g3_d = cm; end
      hsv2rgb_pkg::SecGrnCyn: begin g3_d = cm; b3_d = xm; end
      hsv2rgb_pkg::SecCynBlu: begin g3_d = xm; b3_d = cm; end
      hsv2rgb_pkg::SecBluMag: begin r3_d = xm; b3_d = cm; end
      hsv2rgb_pkg::SecMagRed: begin r3_d = cm; b3_d = xm; end
      default: begin end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      ok3_q <= ok2_q;
      r3_q  <= r3_d;
      g3_q  <= g3_d;
      b3_q  <= b3_d;
    end
  end

  // Stage 4: scale to 0..255, zero on rejected input
  hsv2rgb_pkg::rgb_t res4_d, res4_q;

  always_comb begin
    res4_d.valid_res = ok3_q;
    res4_d.red   = ok3_q ? scale_chan(r3_q) : '0;
    res4_d.green = ok3_q ? scale_chan(g3_q) : '0;
    res4_d.blue  = ok3_q ? scale_chan(b3_q) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && v3_q) begin
      res4_q <= res4_d;
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = res4_q;

  `HSV_ASSERT_SAME(a_stall_only_when_full, clk_i, rst_ni, in_stall_o,
    v1_q && v2_q && v3_q && out_valid_o && out_stall_i,
    "input stalled while pipeline has room")

  `HSV_ASSERT_SAME(a_reject_is_black, clk_i, rst_ni, out_valid_o && !out_data_o.valid_res,
    out_data_o.red == '0 && out_data_o.green == '0 && out_data_o.blue == '0,
    "rejected request produced nonzero color")

  `HSV_ASSERT_NEXT(a_stage1_advance, clk_i, rst_ni, v1_q && rdy2 && !(rdy1 && in_valid_i),
    v2_q && !v1_q,
    "stage 1 request lost or duplicated")

endmodule

// File: tb/sv/hsv_to_rgb_converter_tb.sv
`timescale 1ns / 100ps

module hsv_to_rgb_converter_tb;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall_o;
  hsv2rgb_pkg::hsv_t in_data = '0;
  logic out_valid_o;
  logic out_stall = 1'b0;
  hsv2rgb_pkg::rgb_t out_data_o;

  hsv2rgb_pkg::hsv_t pending_hsv[$];
  hsv2rgb_pkg::rgb_t expected_rgb[$];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatches = 0;
  hsv2rgb_pkg::rgb_t want;

  hsv_to_rgb_converter u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // floor(n * 255 / (65536 * 60)), saturated at full scale
  function automatic logic [hsv2rgb_pkg::ChanW-1:0] to_channel(logic [63:0] n);
    logic [63:0] q;
    q = (n * 64'd255) / (64'd65536 * 64'(hsv2rgb_pkg::SectorDeg));
    return (q > 64'd255) ? 8'd255 : q[hsv2rgb_pkg::ChanW-1:0];
  endfunction

  function automatic hsv2rgb_pkg::rgb_t predict_rgb(hsv2rgb_pkg::hsv_t px);
    hsv2rgb_pkg::rgb_t res;
    hsv2rgb_pkg::sector_e sec;
    logic [63:0] chroma, ramp, offset, hue_mod, hue_dist, deg;
    logic [63:0] sum_r, sum_g, sum_b;
    res = '0;
    if (px.hue > hsv2rgb_pkg::HueMax || px.saturation > hsv2rgb_pkg::UnitOne ||
        px.brightness > hsv2rgb_pkg::UnitOne) begin
      return res;
    end
    deg = 64'(hsv2rgb_pkg::SectorDeg);
    hue_mod = 64'(px.hue) % (deg * 64'd2);
    hue_dist = (hue_mod >= deg) ? hue_mod - deg : deg - hue_mod;
    chroma = 64'(px.saturation) * 64'(px.brightness) * deg;
    ramp = 64'(px.saturation) * 64'(px.brightness) * (deg - hue_dist);
    offset = 64'(px.brightness) * (64'(hsv2rgb_pkg::UnitOne) - 64'(px.saturation)) * deg;
    // hue of exactly 360 folds into the last sector
    if (px.hue >= 9'd300) begin
      sec = hsv2rgb_pkg::SecMagRed;
    end else begin
      sec = hsv2rgb_pkg::sector_e'(3'(px.hue / 9'd60));
    end
    case (sec)
      hsv2rgb_pkg::SecRedYel: begin sum_r = chroma; sum_g = ramp;   sum_b = '0;     end
      hsv2rgb_pkg::SecYelGrn: begin sum_r = ramp;   sum_g = chroma; sum_b = '0;     end
      hsv2rgb_pkg::SecGrnCyn: begin sum_r = '0;     sum_g = chroma; sum_b = ramp;   end
      hsv2rgb_pkg::SecCynBlu: begin sum_r = '0;     sum_g = ramp;   sum_b = chroma; end
      hsv2rgb_pkg::SecBluMag: begin sum_r = ramp;   sum_g = '0;     sum_b = chroma; end
      default: begin   sum_r = chroma; sum_g = '0;     sum_b = ramp;   end
    endcase
    res.red = to_channel(sum_r + offset);
    res.green = to_channel(sum_g + offset);
    res.blue = to_channel(sum_b + offset);
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic queue_hsv(int unsigned h, int unsigned s, int unsigned v);
    hsv2rgb_pkg::hsv_t px;
    px.hue = h[hsv2rgb_pkg::InW-1:0];
    px.saturation = s[hsv2rgb_pkg::InW-1:0];
    px.brightness = v[hsv2rgb_pkg::InW-1:0];
    pending_hsv.push_back(px);
  endtask

  task automatic check_field(string name, int unsigned exp_val, int unsigned got_val);
    if (exp_val != got_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, got_val);
      mismatches++;
    end
  endtask

  // Request driver: the expected color is recorded when a request is presented,
  // since a presented request is never withdrawn.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || !in_stall_o) begin
      if (pending_hsv.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_hsv[0];
        expected_rgb.push_back(predict_rgb(pending_hsv[0]));
        void'(pending_hsv.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall) begin
        if (expected_rgb.size() == 0) begin
          $error("result with no request outstanding: %h", out_data_o);
          mismatches++;
        end else begin
          want = expected_rgb.pop_front();
          check_field("red", 32'(want.red), 32'(out_data_o.red));
          check_field("green", 32'(want.green), 32'(out_data_o.green));
          check_field("blue", 32'(want.blue), 32'(out_data_o.blue));
          check_field("valid_res", 32'(want.valid_res), 32'(out_data_o.valid_res));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  initial begin
    int unsigned pick;
    send_idle_pct = 35;
    recv_stall_pct = 68;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // sector starts and the wrap at 360
    queue_hsv(0, 256, 256);
    queue_hsv(60, 256, 256);
    queue_hsv(120, 256, 256);
    queue_hsv(180, 256, 256);
    queue_hsv(240, 256, 256);
    queue_hsv(300, 256, 256);
    queue_hsv(360, 256, 256);
    // sector ends and mid-sector
    queue_hsv(59, 256, 256);
    queue_hsv(119, 200, 128);
    queue_hsv(239, 100, 256);
    queue_hsv(299, 256, 50);
    queue_hsv(330, 128, 200);
    queue_hsv(150, 77, 255);
    // gray and black
    queue_hsv(200, 0, 256);
    queue_hsv(45, 256, 0);
    queue_hsv(0, 0, 0);
    // rejected inputs
    queue_hsv(361, 0, 0);
    queue_hsv(511, 511, 511);
    queue_hsv(0, 257, 0);
    queue_hsv(0, 0, 257);
    queue_hsv(100, 511, 10);
    queue_hsv(100, 10, 511);

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin send_idle_pct = 35; recv_stall_pct = 68; end
        1: begin send_idle_pct = 68; recv_stall_pct = 35; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int n = 0; n < 234; n++) begin
        pick = $urandom_range(9);
        if (pick < 7) begin
          queue_hsv($urandom_range(360), $urandom_range(256), $urandom_range(256));
        end else if (pick == 7) begin
          queue_hsv($urandom_range(6) * 60 + $urandom_range(1),
                    $urandom_range(1) ? 256 : $urandom_range(2),
                    $urandom_range(1) ? 256 - $urandom_range(1) : $urandom_range(1));
        end else begin
          queue_hsv($urandom_range(511), $urandom_range(511), $urandom_range(511));
        end
      end
      // hold off the next batch until every queued request has come back
      while (pending_hsv.size() != 0 || expected_rgb.size() != 0) @(negedge clk_i);
    end

    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
